>>> hw/rtl/mstc_pkg.sv
// Shared constants for the minimum spanning tree cost block.
// No dependencies.
`timescale 1ns / 1ps

package mstc_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_EDGES_DEF    = 4096;
    localparam int COST_BITS_DEF    = 32;

    localparam int VERT_W   = 10;   // endpoint field width
    localparam int VCOUNT_W = 11;   // vertex count register width
    localparam int SUM_W    = 44;   // total cost width

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 11'd1024;

endpackage

>>> hw/rtl/mstc_edge_ram.sv
// Edge record memory: one write port, two registered read ports.
// Depends on nothing; sized by its parameters.
`timescale 1ns / 1ps

module mstc_edge_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 52
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr0,
    input  logic [AW-1:0] raddr1,
    output logic [DW-1:0] rdata0,
    output logic [DW-1:0] rdata1
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

>>> hw/rtl/minimum_spanning_tree_cost_top.sv
// Minimum spanning tree cost top level: Kruskal with union-find; uses mstc_pkg, mstc_edge_ram.
// Throughput: one edge word per cycle while loading; input stalls from the last word until
// its total is taken into the output register (held while an earlier total is unread).
// After the last word: ceil(log2 n) merge passes sort edges by cost, all MAX_VERTICES forest
// entries cleared; then each edge is fetched, its ends found and compressed, and a union made.
// Reset (aresetn low, synchronous): empty edge store, vertex count 1024, no total pending.
`timescale 1ns / 1ps

module minimum_spanning_tree_cost_top #(
    parameter int MAX_VERTICES = mstc_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = mstc_pkg::MAX_EDGES_DEF,
    parameter int COST_BITS    = mstc_pkg::COST_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config
    input  logic                          cfg_wr_en,
    input  logic [mstc_pkg::VCOUNT_W-1:0] cfg_wr_data,
    // edge words in
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mstc_pkg::VERT_W-1:0]   s_edge_start,
    input  logic [mstc_pkg::VERT_W-1:0]   s_edge_end,
    input  logic signed [COST_BITS-1:0]   s_edge_cost,
    input  logic                          s_last_edge,
    // result words out
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [mstc_pkg::SUM_W-1:0] m_tree_cost,
    output logic                          m_bad_edge_seen
);

    import mstc_pkg::*;

    localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW  = $clog2(MAX_EDGES + 1);       // edge count
    localparam int PW  = EW + 2;                      // merge positions
    localparam int DW  = 2 * VERT_W + COST_BITS;      // edge record
    localparam int VW  = $clog2(MAX_VERTICES);        // vertex index
    localparam int SW  = VW + 1;                      // tree size
    localparam int FW  = VW + SW;                     // forest entry
    localparam int CW  = ((VW > VERT_W) ? VW : VERT_W) + 1;

    typedef enum logic [12:0] {
        S_LOAD     = 13'b0000000000001,
        S_SORT_RD  = 13'b0000000000010,
        S_SORT_WR  = 13'b0000000000100,
        S_CLR      = 13'b0000000001000,
        S_EDGE_RD  = 13'b0000000010000,
        S_EDGE_CHK = 13'b0000000100000,
        S_FIND_RD  = 13'b0000001000000,
        S_FIND_CHK = 13'b0000010000000,
        S_COMP_RD  = 13'b0000100000000,
        S_COMP_CHK = 13'b0001000000000,
        S_UNI_ROOT = 13'b0010000000000,
        S_UNI_LINK = 13'b0100000000000,
        S_DONE     = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [VCOUNT_W-1:0] vc_reg;
    logic [EW-1:0]       count_reg, count_next;
    logic [EW-1:0]       e_reg, e_next;
    logic [PW-1:0]       w_reg, w_next, lo_reg, lo_next, mid_reg, mid_next;
    logic [PW-1:0]       hi_reg, hi_next, i_reg, i_next, j_reg, j_next;
    logic [PW-1:0]       k_reg, k_next;
    logic                src_reg, src_next;
    logic [VW-1:0]       clr_reg, clr_next;
    logic [VW-1:0]       b_reg, b_next;
    logic [COST_BITS-1:0] cost_reg, cost_next;
    logic [VW-1:0]       r_reg, r_next, v_reg, v_next;
    logic                phase_reg, phase_next;
    logic [VW-1:0]       ra_reg, ra_next, rb_reg, rb_next;
    logic [SW-1:0]       sa_reg, sa_next, sb_reg, sb_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                bad_reg, bad_next;
    logic                mv_reg, mv_next;
    logic [SUM_W-1:0]    mcost_reg, mcost_next;
    logic                mbad_reg, mbad_next;

    // edge memories
    logic          we0, we1;
    logic [AW-1:0] waddr, raddr0, raddr1;
    logic [DW-1:0] wdata, q00, q01, q10, q11, src0, src1;

    // forest memory: {parent, size}
    logic [FW-1:0] forest [MAX_VERTICES];
    logic          f_we;
    logic [VW-1:0] f_waddr, f_raddr;
    logic [FW-1:0] f_wdata, f_q;
    logic [VW-1:0] f_par;
    logic [SW-1:0] f_size;

    mstc_edge_ram #(.DEPTH(MAX_EDGES), .AW(AW), .DW(DW)) u_ram0 (
        .aclk(aclk), .we(we0), .waddr(waddr), .wdata(wdata),
        .raddr0(raddr0), .raddr1(raddr1), .rdata0(q00), .rdata1(q01)
    );

    mstc_edge_ram #(.DEPTH(MAX_EDGES), .AW(AW), .DW(DW)) u_ram1 (
        .aclk(aclk), .we(we1), .waddr(waddr), .wdata(wdata),
        .raddr0(raddr0), .raddr1(raddr1), .rdata0(q10), .rdata1(q11)
    );

    always_ff @(posedge aclk) begin
        if (f_we) begin
            forest[f_waddr] <= f_wdata;
        end
        f_q <= forest[f_raddr];
    end

    assign f_par  = f_q[FW-1:SW];
    assign f_size = f_q[SW-1:0];
    assign src0   = src_reg ? q10 : q00;
    assign src1   = src_reg ? q11 : q01;

    // vertex count in effect, clamped to the forest size
    logic [CW-1:0] vc_ext, vc_eff, a_ext, b_ext;
    assign vc_ext = CW'(vc_reg);
    assign vc_eff = (vc_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_ext;

    logic [PW-1:0] n_ext;
    assign n_ext = PW'(count_reg);

    logic [VERT_W-1:0]    rec_a, rec_b;
    logic [COST_BITS-1:0] rec_c;
    assign rec_a = src0[DW-1 -: VERT_W];
    assign rec_b = src0[DW-1-VERT_W -: VERT_W];
    assign rec_c = src0[COST_BITS-1:0];
    assign a_ext = CW'(rec_a);
    assign b_ext = CW'(rec_b);

    logic           take_j;
    logic [PW-1:0]  lo2, w2, blk_lo, blk_w, blk_mid, blk_hi;
    logic           blk_go;
    logic [63:0]    cost_sx;
    logic [EW-1:0]  n_load;
    logic           s_acc;

    assign s_ready = (state_reg == S_LOAD);
    assign s_acc   = s_valid & s_ready;

    assign take_j = (j_reg < hi_reg) &&
                    ((i_reg >= mid_reg) ||
                     ($signed(src1[COST_BITS-1:0]) < $signed(src0[COST_BITS-1:0])));
    assign cost_sx = {{(64-COST_BITS){cost_reg[COST_BITS-1]}}, cost_reg};

    // merge block bounds
    always_comb begin
        blk_mid = ((blk_lo + blk_w) < n_ext) ? (blk_lo + blk_w) : n_ext;
        blk_hi  = ((blk_lo + (blk_w << 1)) < n_ext) ? (blk_lo + (blk_w << 1)) : n_ext;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        e_next     = e_reg;
        w_next     = w_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        src_next   = src_reg;
        clr_next   = clr_reg;
        b_next     = b_reg;
        cost_next  = cost_reg;
        r_next     = r_reg;
        v_next     = v_reg;
        phase_next = phase_reg;
        ra_next    = ra_reg;
        rb_next    = rb_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        sum_next   = sum_reg;
        bad_next   = bad_reg;
        mv_next    = mv_reg & ~m_ready;
        mcost_next = mcost_reg;
        mbad_next  = mbad_reg;
        we0        = 1'b0;
        we1        = 1'b0;
        waddr      = k_reg[AW-1:0];
        wdata      = take_j ? src1 : src0;
        raddr0     = i_reg[AW-1:0];
        raddr1     = j_reg[AW-1:0];
        f_we       = 1'b0;
        f_waddr    = v_reg;
        f_wdata    = {r_reg, f_size};
        f_raddr    = r_reg;
        blk_lo     = lo_reg;
        blk_w      = w_reg;
        blk_go     = 1'b0;
        lo2        = lo_reg + (w_reg << 1);
        w2         = w_reg << 1;
        n_load     = count_reg;

        case (state_reg)
            S_LOAD: begin
                waddr = count_reg[AW-1:0];
                wdata = {s_edge_start, s_edge_end, s_edge_cost};
                if (s_acc) begin
                    if (count_reg < EW'(MAX_EDGES)) begin
                        we0    = 1'b1;
                        n_load = count_reg + EW'(1);
                    end
                    count_next = n_load;
                    if (s_last_edge) begin
                        src_next = 1'b0;
                        clr_next = '0;
                        if (n_load > EW'(1)) begin
                            w_next  = PW'(1);
                            lo_next = '0;
                            i_next  = '0;
                            k_next  = '0;
                            // first block of width one
                            mid_next = PW'(1);
                            j_next   = PW'(1);
                            hi_next  = PW'(2);
                            state_next = S_SORT_RD;
                        end else begin
                            state_next = S_CLR;
                        end
                    end
                end
            end
            S_SORT_RD: begin
                state_next = S_SORT_WR;
            end
            S_SORT_WR: begin
                we0 = src_reg;
                we1 = ~src_reg;
                if (take_j) j_next = j_reg + PW'(1);
                else        i_next = i_reg + PW'(1);
                k_next     = k_reg + PW'(1);
                state_next = S_SORT_RD;
                if (k_reg + PW'(1) == hi_reg) begin
                    if (lo2 >= n_ext) begin
                        src_next = ~src_reg;
                        if (w2 >= n_ext) begin
                            state_next = S_CLR;
                        end else begin
                            blk_lo = '0;
                            blk_w  = w2;
                            blk_go = 1'b1;
                        end
                    end else begin
                        blk_lo = lo2;
                        blk_go = 1'b1;
                    end
                end
                if (blk_go) begin
                    w_next   = blk_w;
                    lo_next  = blk_lo;
                    mid_next = blk_mid;
                    hi_next  = blk_hi;
                    i_next   = blk_lo;
                    j_next   = blk_mid;
                    k_next   = blk_lo;
                end
            end
            S_CLR: begin
                f_we     = 1'b1;
                f_waddr  = clr_reg;
                f_wdata  = {clr_reg, SW'(1)};
                clr_next = clr_reg + VW'(1);
                if (clr_reg == VW'(MAX_VERTICES - 1)) begin
                    e_next     = '0;
                    state_next = S_EDGE_RD;
                end
            end
            S_EDGE_RD: begin
                raddr0 = e_reg[AW-1:0];
                if (e_reg == count_reg) state_next = S_DONE;
                else                    state_next = S_EDGE_CHK;
            end
            S_EDGE_CHK: begin
                cost_next = rec_c;
                if (a_ext >= vc_eff || b_ext >= vc_eff) begin
                    bad_next   = 1'b1;
                    e_next     = e_reg + EW'(1);
                    state_next = S_EDGE_RD;
                end else begin
                    b_next     = b_ext[VW-1:0];
                    r_next     = a_ext[VW-1:0];
                    v_next     = a_ext[VW-1:0];
                    phase_next = 1'b0;
                    state_next = S_FIND_RD;
                end
            end
            S_FIND_RD: begin
                f_raddr    = r_reg;
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                if (f_par == r_reg) begin
                    if (phase_reg) sb_next = f_size;
                    else           sa_next = f_size;
                    state_next = S_COMP_RD;
                end else begin
                    r_next     = f_par;
                    state_next = S_FIND_RD;
                end
            end
            S_COMP_RD: begin
                f_raddr    = v_reg;
                state_next = S_COMP_CHK;
            end
            S_COMP_CHK: begin
                if (f_par == r_reg) begin
                    if (!phase_reg) begin
                        ra_next    = r_reg;
                        phase_next = 1'b1;
                        r_next     = b_reg;
                        v_next     = b_reg;
                        state_next = S_FIND_RD;
                    end else if (ra_reg == r_reg) begin
                        e_next     = e_reg + EW'(1);
                        state_next = S_EDGE_RD;
                    end else begin
                        rb_next    = r_reg;
                        state_next = S_UNI_ROOT;
                    end
                end else begin
                    // path compression
                    f_we       = 1'b1;
                    f_waddr    = v_reg;
                    f_wdata    = {r_reg, f_size};
                    v_next     = f_par;
                    state_next = S_COMP_RD;
                end
            end
            S_UNI_ROOT: begin
                f_we    = 1'b1;
                f_waddr = (sa_reg < sb_reg) ? rb_reg : ra_reg;
                f_wdata = {f_waddr, sa_reg + sb_reg};
                state_next = S_UNI_LINK;
            end
            S_UNI_LINK: begin
                f_we = 1'b1;
                if (sa_reg < sb_reg) begin
                    f_waddr = ra_reg;
                    f_wdata = {rb_reg, sa_reg};
                end else begin
                    f_waddr = rb_reg;
                    f_wdata = {ra_reg, sb_reg};
                end
                sum_next   = sum_reg + cost_sx[SUM_W-1:0];
                e_next     = e_reg + EW'(1);
                state_next = S_EDGE_RD;
            end
            S_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mcost_next = sum_reg;
                    mbad_next  = bad_reg;
                    sum_next   = '0;
                    bad_next   = 1'b0;
                    count_next = '0;
                    src_next   = 1'b0;
                    state_next = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            vc_reg    <= VCOUNT_RESET;
            count_reg <= '0;
            sum_reg   <= '0;
            bad_reg   <= 1'b0;
            mv_reg    <= 1'b0;
            src_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) vc_reg <= cfg_wr_data;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            bad_reg   <= bad_next;
            mv_reg    <= mv_next;
            src_reg   <= src_next;
        end
    end

    always_ff @(posedge aclk) begin
        e_reg     <= e_next;
        w_reg     <= w_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        clr_reg   <= clr_next;
        b_reg     <= b_next;
        cost_reg  <= cost_next;
        r_reg     <= r_next;
        v_reg     <= v_next;
        phase_reg <= phase_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        sa_reg    <= sa_next;
        sb_reg    <= sb_next;
        mcost_reg <= mcost_next;
        mbad_reg  <= mbad_next;
    end

    assign m_valid         = mv_reg;
    assign m_tree_cost     = mcost_reg;
    assign m_bad_edge_seen = mbad_reg;

endmodule
